@@ hdl/lkvc_pkg.sv @@
// Shared constants and types for the LRU key-value cache.
// No dependencies; every other file of the block imports this package.
package lkvc_pkg;

    localparam int WORD_W          = 32;
    localparam int CAP_W           = 5;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_BITS_DEF    = 32;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [WORD_W-1:0] MISS_VALUE = {WORD_W{1'b1}};

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic start;   // latch request, clear scan trackers
        logic rd_en;   // read one entry at the scan index
        logic update;  // commit the request and load the result register
    } t_lkvc_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_stall;  // result register full and not being taken
    } t_lkvc_sts;

endpackage

@@ hdl/lkvc_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on lkvc_pkg for the field widths.
interface lkvc_req_if import lkvc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic signed [WORD_W-1:0] key;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output mode, output key, output value, input ready);
    modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic signed [WORD_W-1:0] read_value;
    logic                     evicted;

    modport source (output valid, output hit, output read_value, output evicted, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted, output ready);
endinterface

@@ hdl/lkvc_ctrl.sv @@
// Sequencer of the LRU cache: accept, scan every entry, drain, commit.
// Depends on lkvc_pkg for the command and status types.
module lkvc_ctrl import lkvc_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_lkvc_sts        i_sts,
    output t_lkvc_cmd        o_cmd,
    output logic [IDX_W-1:0] o_rd_idx
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_UPDATE = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_idx       = '0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            // last compare lands in the trackers
            S_DRAIN: begin
                n_state = S_UPDATE;
            end
            // hold until the result register can take the beat
            S_UPDATE: begin
                if (!i_sts.out_stall) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rd_idx = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    a_start_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_SCAN && r_idx == '0))
        else $error("accepted request did not start a scan at entry zero");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_idx == LAST_IDX) |=> (r_state == S_DRAIN))
        else $error("scan did not end after the last entry");

endmodule

@@ hdl/lkvc_dp.sv @@
// Datapath of the LRU cache: key/value memories, valid bits, age ranks,
// scan trackers, occupancy, capacity register and the result register.
// Depends on lkvc_pkg.
module lkvc_dp import lkvc_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_lkvc_cmd                i_cmd,
    input  logic [IDX_W-1:0]         i_rd_idx,
    output t_lkvc_sts                o_sts,
    input  logic                     i_mode,
    input  logic signed [WORD_W-1:0] i_key,
    input  logic signed [WORD_W-1:0] i_value,
    input  logic                     i_cfg_we,
    input  logic [CAP_W-1:0]         i_cfg_wdata,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_hit,
    output logic signed [WORD_W-1:0] o_read_value,
    output logic                     o_evicted
);

    localparam int CMP_W  = (KEY_BITS < WORD_W) ? KEY_BITS : WORD_W;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CW     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // storage
    logic [CMP_W-1:0]       r_key_mem [MAX_ENTRIES];
    logic [WORD_W-1:0]      r_val_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [RANK_W-1:0]      r_rank [MAX_ENTRIES];
    logic [CNT_W-1:0]       r_occ;
    logic [CAP_W-1:0]       r_cap;

    // latched request
    logic              r_mode;
    logic [CMP_W-1:0]  r_key;
    logic [WORD_W-1:0] r_value;

    // read stage
    logic              r_q_vld;
    logic [IDX_W-1:0]  r_q_idx;
    logic [CMP_W-1:0]  r_rd_key;
    logic [WORD_W-1:0] r_rd_val;

    // scan trackers
    logic              r_found;
    logic [IDX_W-1:0]  r_found_idx;
    logic [WORD_W-1:0] r_found_val;
    logic [RANK_W-1:0] r_found_rank;
    logic              r_free_got;
    logic [IDX_W-1:0]  r_free_idx;
    logic              r_lru_got;
    logic [IDX_W-1:0]  r_lru_idx;
    logic [RANK_W-1:0] r_lru_rank;

    // result register
    logic              r_out_valid;
    logic              r_out_hit;
    logic [WORD_W-1:0] r_out_data;
    logic              r_out_evicted;

    // compare stage
    logic              q_valid;
    logic [RANK_W-1:0] q_rank;
    logic              q_match;

    // commit decisions
    logic [CW-1:0]     eff_cap;
    logic              below_cap;
    logic              do_touch;
    logic [IDX_W-1:0]  touch_idx;
    logic [RANK_W-1:0] touch_rank;
    logic              do_insert;
    logic              do_evict;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [WORD_W-1:0] res_data;

    assign q_valid = r_valid[r_q_idx];
    assign q_rank  = r_rank[r_q_idx];
    assign q_match = r_q_vld && q_valid && (r_rd_key == r_key);

    always_comb begin
        // capacity zero acts as one, above the store size as the store size
        if (CW'(r_cap) == '0) begin
            eff_cap = CW'(1);
        end else if (CW'(r_cap) > CW'(MAX_ENTRIES)) begin
            eff_cap = CW'(MAX_ENTRIES);
        end else begin
            eff_cap = CW'(r_cap);
        end
    end

    assign below_cap  = CW'(r_occ) < eff_cap;
    assign do_insert  = (r_mode == MODE_PUT) && !r_found && below_cap && r_free_got;
    assign do_evict   = (r_mode == MODE_PUT) && !r_found && !below_cap && r_lru_got;
    assign do_touch   = r_found || do_evict;
    assign touch_idx  = r_found ? r_found_idx : r_lru_idx;
    assign touch_rank = r_found ? r_found_rank : r_lru_rank;
    assign wr_en      = (r_mode == MODE_PUT) && (r_found || do_insert || do_evict);
    assign wr_idx     = r_found ? r_found_idx : (do_insert ? r_free_idx : r_lru_idx);
    assign res_data   = (r_mode == MODE_PUT) ? r_value :
                        (r_found ? r_found_val : MISS_VALUE);

    // key/value memories: one read port for the scan, one write port at commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_key <= r_key_mem[i_rd_idx];
            r_rd_val <= r_val_mem[i_rd_idx];
        end
        if (i_cmd.update && wr_en) begin
            r_key_mem[wr_idx] <= r_key;
            r_val_mem[wr_idx] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode  <= i_mode;
            r_key   <= i_key[CMP_W-1:0];
            r_value <= i_value;
        end
        r_q_idx <= i_rd_idx;
    end

    // trackers: first match, first free entry, first entry of highest rank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld    <= 1'b0;
            r_found    <= 1'b0;
            r_free_got <= 1'b0;
            r_lru_got  <= 1'b0;
        end else begin
            r_q_vld <= i_cmd.rd_en;
            if (i_cmd.start) begin
                r_found    <= 1'b0;
                r_free_got <= 1'b0;
                r_lru_got  <= 1'b0;
            end else if (r_q_vld) begin
                if (q_match && !r_found) begin
                    r_found <= 1'b1;
                end
                if (!q_valid && !r_free_got) begin
                    r_free_got <= 1'b1;
                end
                if (q_valid) begin
                    r_lru_got <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_q_vld && !i_cmd.start) begin
            if (q_match && !r_found) begin
                r_found_idx  <= r_q_idx;
                r_found_val  <= r_rd_val;
                r_found_rank <= q_rank;
            end
            if (!q_valid && !r_free_got) begin
                r_free_idx <= r_q_idx;
            end
            if (q_valid && (!r_lru_got || q_rank > r_lru_rank)) begin
                r_lru_idx  <= r_q_idx;
                r_lru_rank <= q_rank;
            end
        end
    end

    // valid bits and age ranks, updated per entry at commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.update) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (do_touch) begin
                    if (IDX_W'(i) == touch_idx) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && r_rank[i] < touch_rank) begin
                        r_rank[i] <= r_rank[i] + RANK_W'(1);
                    end
                end else if (do_insert) begin
                    if (IDX_W'(i) == r_free_idx) begin
                        r_rank[i]  <= '0;
                        r_valid[i] <= 1'b1;
                    end else if (r_valid[i]) begin
                        r_rank[i] <= r_rank[i] + RANK_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
            r_cap <= CAP_RESET;
        end else begin
            if (i_cmd.update && do_insert) begin
                r_occ <= r_occ + CNT_W'(1);
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // result register: load at commit, drop when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.update) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_out_hit     <= r_found;
            r_out_data    <= res_data;
            r_out_evicted <= do_evict;
        end
    end

    assign o_sts.out_stall = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_read_value    = r_out_data;
    assign o_evicted       = r_out_evicted;

    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy does not match the number of valid entries");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> !(r_out_valid && !i_out_ready))
        else $error("commit while the result register is stalled");

    a_evict_keeps_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && do_evict) |=> (r_occ == $past(r_occ)))
        else $error("eviction changed occupancy");

endmodule

@@ hdl/lru_key_value_cache.sv @@
// Top level of the LRU key-value cache: controller plus datapath.
// Depends on lkvc_pkg, lkvc_if, lkvc_ctrl and lkvc_dp.
//
//   channel   dir  handshake        payload
//   i_req     in   valid/ready      mode, key, value
//   o_rsp     out  valid/ready      hit, read_value, evicted
//   i_cfg     in   i_cfg_we only    i_cfg_wdata (capacity)
//
// A request goes through the accept, a scan that reads each entry in turn
// through the single read port of the key and value memories, a drain state
// for the last compare and the commit; the next accept follows the commit.
// The result beat appears in the cycle after the commit and waits in a
// register; the next request is accepted meanwhile, and only its commit
// holds while that beat is not taken. Reset is synchronous and active low,
// empties the store and sets the capacity to 16.
module lru_key_value_cache import lkvc_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lkvc_req_if.sink         i_req,
    lkvc_rsp_if.source       o_rsp,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    t_lkvc_cmd        cmd;
    t_lkvc_sts        sts;
    logic [IDX_W-1:0] rd_idx;

    lkvc_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_rd_idx   (rd_idx)
    );

    lkvc_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .IDX_W       (IDX_W)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_rd_idx     (rd_idx),
        .o_sts        (sts),
        .i_mode       (i_req.mode),
        .i_key        (i_req.key),
        .i_value      (i_req.value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_out_valid  (o_rsp.valid),
        .i_out_ready  (o_rsp.ready),
        .o_hit        (o_rsp.hit),
        .o_read_value (o_rsp.read_value),
        .o_evicted    (o_rsp.evicted)
    );

endmodule

@@ bench/lkvc_cache_checker.sv @@
`timescale 1ns / 1ps
// Checker for the LRU key-value cache: watches the request, result and capacity ports.
// Predicts one result per request beat and compares it with the result beats in order.
// Depends on lkvc_pkg and the channel interfaces of lkvc_if.
module lkvc_cache_checker import lkvc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lkvc_req_if              req,
    lkvc_rsp_if              rsp,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_outstanding,
    output int               o_hits,
    output int               o_evictions
);

    localparam int SLOTS = MAX_ENTRIES_DEF;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] read_value;
        logic              evicted;
    } t_cache_result;

    // Shadow copy of the store
    logic [WORD_W-1:0] slot_key   [SLOTS];
    logic [WORD_W-1:0] slot_value [SLOTS];
    logic              slot_valid [SLOTS];
    logic [3:0]        slot_rank  [SLOTS];
    int                occupancy;
    logic [CAP_W-1:0]  capacity;

    t_cache_result expected_results[$];
    int            fail_total;
    int            hit_total;
    int            evict_total;

    assign o_fail_count = fail_total;
    assign o_hits       = hit_total;
    assign o_evictions  = evict_total;

    // Make a slot most recent; entries younger than it age by one.
    function automatic void promote(int slot);
        for (int i = 0; i < SLOTS; i++) begin
            if (i != slot && slot_valid[i] && slot_rank[i] < slot_rank[slot])
                slot_rank[i] = slot_rank[i] + 4'd1;
        end
        slot_rank[slot] = 4'd0;
    endfunction

    function automatic t_cache_result apply_request(logic mode, logic [WORD_W-1:0] key,
                                                    logic [WORD_W-1:0] value);
        t_cache_result r;
        int found;
        int slot;
        int eff_cap;
        found   = -1;
        slot    = -1;
        eff_cap = (capacity == 0) ? 1 : (capacity > SLOTS) ? SLOTS : int'(capacity);
        for (int i = 0; i < SLOTS; i++) begin
            if (found < 0 && slot_valid[i] && slot_key[i] == key)
                found = i;
        end
        r.hit     = (found >= 0);
        r.evicted = 1'b0;
        if (mode == MODE_GET) begin
            r.read_value = MISS_VALUE;
            if (found >= 0) begin
                r.read_value = slot_value[found];
                promote(found);
            end
        end else begin
            r.read_value = value;
            if (found >= 0) begin
                slot_value[found] = value;
                promote(found);
            end else if (occupancy < eff_cap) begin
                // lowest free slot; everything already present gets older
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot < 0 && !slot_valid[i])
                        slot = i;
                end
                if (slot >= 0) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_valid[i])
                            slot_rank[i] = slot_rank[i] + 4'd1;
                    end
                    slot_valid[slot] = 1'b1;
                    slot_key[slot]   = key;
                    slot_value[slot] = value;
                    slot_rank[slot]  = 4'd0;
                    occupancy++;
                end
            end else begin
                // replace the oldest entry, occupancy unchanged
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_valid[i] && (slot < 0 || slot_rank[i] > slot_rank[slot]))
                        slot = i;
                end
                if (slot >= 0) begin
                    slot_key[slot]   = key;
                    slot_value[slot] = value;
                    promote(slot);
                    r.evicted = 1'b1;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_cache_result exp_r;
        t_cache_result got_r;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_valid[i] = 1'b0;
                slot_rank[i]  = 4'd0;
                slot_key[i]   = '0;
                slot_value[i] = '0;
            end
            occupancy   = 0;
            capacity    = CAP_RESET;
            fail_total  = 0;
            hit_total   = 0;
            evict_total = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we)
                capacity = i_cfg_wdata;
            if (rsp.valid && rsp.ready) begin
                got_r.hit        = rsp.hit;
                got_r.read_value = rsp.read_value;
                got_r.evicted    = rsp.evicted;
                if (expected_results.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: result beat with nothing pending: %s",
                                 $realtime,
                                 $sformatf("hit=%0b value=%h evicted=%0b",
                                           got_r.hit, got_r.read_value, got_r.evicted));
                end else begin
                    exp_r = expected_results.pop_front();
                    hit_total   += exp_r.hit;
                    evict_total += exp_r.evicted;
                    if (got_r.hit !== exp_r.hit || got_r.read_value !== exp_r.read_value ||
                        got_r.evicted !== exp_r.evicted) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("%0t: result mismatch: expected %s, got %s",
                                     $realtime,
                                     $sformatf("hit=%0b value=%h evicted=%0b",
                                               exp_r.hit, exp_r.read_value, exp_r.evicted),
                                     $sformatf("hit=%0b value=%h evicted=%0b",
                                               got_r.hit, got_r.read_value, got_r.evicted));
                    end
                end
            end
            if (req.valid && req.ready)
                expected_results.push_back(apply_request(req.mode, req.key, req.value));
        end
        o_outstanding <= expected_results.size();
    end

endmodule

@@ bench/tb_lru_key_value_cache.sv @@
`timescale 1ns / 1ps
// Top of the LRU key-value cache bench: clock, reset, request and capacity stimulus.
// Depends on lkvc_pkg, lkvc_if, the cache RTL and lkvc_cache_checker.
module tb_lru_key_value_cache;
    import lkvc_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;

    int fail_count;
    int outstanding;
    int hits;
    int evictions;

    bit                steady;
    int                hot_keys;
    int                items_sent;
    int                settings_used;
    logic [WORD_W-1:0] key_pool [24];

    lkvc_req_if req_ch ();
    lkvc_rsp_if rsp_ch ();

    lru_key_value_cache DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    lkvc_cache_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_hits        (hits),
        .o_evictions   (evictions)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("lru_key_value_cache test failed");
        $finish;
    end

    task automatic send_request(input logic mode, input logic [WORD_W-1:0] key,
                                input logic [WORD_W-1:0] value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode  <= mode;
        req_ch.key   <= key;
        req_ch.value <= value;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        items_sent++;
    endtask

    // Hold off new requests until every result beat has been taken.
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings_used++;
        // a small hot set keeps hits and evictions frequent
        if (cap == 0)
            hot_keys = 3;
        else if (2 * cap + 2 > 24)
            hot_keys = 24;
        else
            hot_keys = 2 * cap + 2;
    endtask

    function automatic logic [WORD_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 8)
            return key_pool[$urandom_range(0, hot_keys - 1)];
        return $urandom;
    endfunction

    function automatic logic [WORD_W-1:0] pick_value();
        if ($urandom_range(0, 9) == 0)
            return key_pool[$urandom_range(0, 3)];
        return $urandom;
    endfunction

    // Result side: drop ready for a random stall before each beat, except in steady phases.
    initial begin
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_ch.valid && rsp_ch.ready));
        end
    end

    initial begin
        logic [CAP_W-1:0] phase_caps [10];
        phase_caps    = '{5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd2, 5'd17, 5'd8, 5'd3, 5'd0};
        phase_caps[9] = CAP_W'($urandom_range(0, 31));
        steady        = 1'b0;
        items_sent    = 0;
        settings_used = 1;
        hot_keys      = 24;
        key_pool[0]   = 32'h0000_0000;
        key_pool[1]   = 32'hFFFF_FFFF;
        key_pool[2]   = 32'h8000_0000;
        key_pool[3]   = 32'h7FFF_FFFF;
        for (int i = 4; i < 24; i++)
            key_pool[i] = $urandom;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        req_ch.valid <= 1'b0;
        req_ch.mode  <= MODE_GET;
        req_ch.key   <= '0;
        req_ch.value <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty store, extreme keys and values, hit and miss of both modes.
        send_request(MODE_GET, 32'h0000_0000, 32'hDEAD_BEEF);
        send_request(MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(MODE_PUT, 32'h0000_0000, 32'h0000_0000);
        send_request(MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(MODE_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(MODE_GET, 32'h0000_0005, 32'h0000_0000);
        send_request(MODE_PUT, 32'h0000_0000, 32'h1234_5678);
        send_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(MODE_PUT, 32'h5555_AAAA, 32'hAAAA_5555);
        // Capacity dropped under the current occupancy: misses must replace, not fill.
        wait_for_drain();
        write_capacity(5'd1);
        send_request(MODE_PUT, 32'h0000_0055, 32'h0F0F_F0F0);
        send_request(MODE_GET, 32'h0000_0055, 32'h0000_0000);
        send_request(MODE_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(MODE_PUT, 32'hAAAA_5555, 32'h5555_AAAA);
        send_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);

        for (int phase = 0; phase < 10; phase++) begin
            wait_for_drain();
            write_capacity(phase_caps[phase]);
            steady = (phase % 4 == 1);
            for (int n = 0; n < 48; n++)
                send_request($urandom_range(0, 1) ? MODE_PUT : MODE_GET, pick_key(), pick_value());
        end
        steady = 1'b0;

        wait_for_drain();
        repeat (40) @(posedge i_clk);
        $display("Sent %0d requests across %0d capacity settings;", items_sent, settings_used);
        $display("%0d hits and %0d evictions checked.", hits, evictions);
        if (fail_count == 0 && outstanding == 0)
            $display("lru_key_value_cache test passed");
        else
            $display("lru_key_value_cache test failed");
        $finish;
    end

endmodule
